### rtl/efla_pkg.sv
// Shared types and constants for the extent free-list allocator.
package efla_pkg;

  // Default table depth and page size.
  localparam int unsigned MAX_EXTENTS_DEF = 64;
  localparam int unsigned PAGE_BYTES_DEF  = 4096;

  // Address and length width of every extent and request.
  localparam int unsigned ADDR_W = 32;

  // Operation carried by the func field of an input word.
  typedef enum logic [0:0] {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOFIT    = 2'd1,
    STAT_MISALIGN = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_SCAN,
    ST_WR,
    ST_FIN
  } state_t;

  // One entry of the extent table.
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] length;
  } extent_t;

endpackage

### rtl/extent_free_list_allocator.sv
// Top level of the first-fit extent allocator: sequencer, extent table memory and totals.

// The block keeps up to MAX_EXTENTS free extents (base, length) in one synchronous memory and
// serves one word at a time. An allocate takes the request from the front of the first extent
// long enough for it. A free grows the first extent that starts just after, or ends exactly at,
// the freed range, and otherwise appends a new extent if the table has room. Each word first
// passes a page-alignment check, of the length and then of the base, which share one multiplier.
// The power-of-two part of the page size is tested with a mask, and the odd part with a
// multiplication by its inverse modulo 2^32. Then a scan reads one table entry per cycle; on a
// hit the updated entry is written back, and the result is then handed to the output register.
// The hand-over waits while the output register still holds a result that has not been taken.
// The result sits in an output register, so the next word is accepted as soon as the sequencer
// is back in idle, even while that result still waits to be taken. A write on the configuration
// port loads the used-byte total with the total RAM size. It is taken only while the sequencer
// is idle and takes precedence over an input word offered in the same cycle. No clearing pass
// is needed after reset: only entries below the fill count are ever compared.
module extent_free_list_allocator #(
  parameter int unsigned MAX_EXTENTS = efla_pkg::MAX_EXTENTS_DEF,
  parameter int unsigned PAGE_BYTES  = efla_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_total_ram,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [31:0] in_base_addr,
  input  logic [31:0] in_length_bytes,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_alloc_addr,
  output logic [1:0]  out_status,
  output logic [31:0] out_free_total,
  output logic [31:0] out_used_total
);

  // Number of trailing zero bits of the page size.
  function automatic int unsigned page_tz(input int unsigned pg);
    int unsigned n;
    logic        stop;
    n    = 0;
    stop = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (!stop && !pg[i]) begin
        n++;
      end else begin
        stop = 1'b1;
      end
    end
    return n;
  endfunction

  // Inverse of an odd number modulo 2^32, by Newton iteration.
  function automatic logic [31:0] odd_inverse(input logic [31:0] d);
    logic [31:0] x;
    x = d;
    for (int i = 0; i < 5; i++) begin
      x = x * (32'd2 - d * x);
    end
    return x;
  endfunction

  // Index width for the table and count width that can also hold the full depth.
  localparam int unsigned IW = $clog2(MAX_EXTENTS);
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EXTENTS);

  // A value is a multiple of the page size when its low bits below the power-of-two part are
  // zero and the rest, times the inverse of the odd part, does not exceed (2^32 - 1) / odd part.
  localparam int unsigned PAGE_TZ   = page_tz(PAGE_BYTES);
  localparam logic [31:0] PAGE_ODD  = 32'(PAGE_BYTES >> PAGE_TZ);
  localparam logic [31:0] PAGE_INV  = odd_inverse(PAGE_ODD);
  localparam logic [31:0] PAGE_LIM  = 32'hFFFF_FFFF / PAGE_ODD;
  localparam logic [31:0] PAGE_MASK = 32'((64'd1 << PAGE_TZ) - 64'd1);

  // Sequencer and control state.
  efla_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [31:0]      free_r, free_nxt;
  logic [31:0]      used_r, used_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Captured request.
  logic             func_r, func_nxt;
  logic [31:0]      base_r, base_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [31:0]      end_r, end_nxt;

  // Alignment check: which field is tested this cycle and the verdict on the length.
  logic             chk_sel_r, chk_sel_nxt;
  logic             len_ok_r, len_ok_nxt;
  logic [31:0]      chk_word, chk_odd;
  logic             chk_ok;

  // Scan pointers and the entry that matched.
  logic [CW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]    chk_idx_r, chk_idx_nxt;
  logic [IW-1:0]    hit_idx_r, hit_idx_nxt;
  efla_pkg::extent_t hit_data_r, hit_data_nxt;
  logic             hit_down_r, hit_down_nxt;

  // Result waiting for the output register.
  logic [31:0]      res_addr_r, res_addr_nxt;
  efla_pkg::status_t res_status_r, res_status_nxt;

  // Output register.
  logic [31:0]      out_addr_r, out_addr_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [31:0]      out_free_r, out_free_nxt;
  logic [31:0]      out_used_r, out_used_nxt;

  // Extent table memory with a registered read port.
  efla_pkg::extent_t mem [MAX_EXTENTS];
  efla_pkg::extent_t rd_data_r;
  logic [IW-1:0]     rd_addr;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  efla_pkg::extent_t mem_wdata;

  // Match terms on the entry just read.
  logic [31:0] ext_end;
  logic        match_alloc, match_down, match_up, scan_hit, scan_done;
  logic        is_alloc;

  assign is_alloc = (func_r == efla_pkg::FUNC_ALLOC);

  // The length is tested first and the base after it.
  assign chk_word = chk_sel_r ? base_r : len_r;
  assign chk_odd  = (chk_word >> PAGE_TZ) * PAGE_INV;
  assign chk_ok   = ((chk_word & PAGE_MASK) == '0) && (chk_odd <= PAGE_LIM);

  assign ext_end     = rd_data_r.base + rd_data_r.length;
  assign match_alloc = (rd_data_r.length >= len_r);
  assign match_down  = (rd_data_r.base == end_r);
  assign match_up    = (ext_end == base_r);
  assign scan_hit    = pend_r && (is_alloc ? match_alloc : (match_down || match_up));
  assign scan_done   = !pend_r && (rd_idx_r >= count_r);

  assign in_ready  = (state_r == efla_pkg::ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == efla_pkg::ST_IDLE);

  assign out_valid      = out_valid_r;
  assign out_alloc_addr = out_addr_r;
  assign out_status     = out_status_r;
  assign out_free_total = out_free_r;
  assign out_used_total = out_used_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    free_nxt       = free_r;
    used_nxt       = used_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    func_nxt       = func_r;
    base_nxt       = base_r;
    len_nxt        = len_r;
    end_nxt        = end_r;
    chk_sel_nxt    = chk_sel_r;
    len_ok_nxt     = len_ok_r;
    rd_idx_nxt     = rd_idx_r;
    chk_idx_nxt    = chk_idx_r;
    hit_idx_nxt    = hit_idx_r;
    hit_data_nxt   = hit_data_r;
    hit_down_nxt   = hit_down_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_free_nxt   = out_free_r;
    out_used_nxt   = out_used_r;
    rd_addr        = rd_idx_r[IW-1:0];
    mem_we         = 1'b0;
    mem_waddr      = hit_idx_r;
    mem_wdata      = hit_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      efla_pkg::ST_IDLE: begin
        if (cfg_valid) begin
          used_nxt = cfg_total_ram;
        end else if (in_valid) begin
          func_nxt    = in_func;
          base_nxt    = in_base_addr;
          len_nxt     = in_length_bytes;
          end_nxt     = in_base_addr + in_length_bytes;
          chk_sel_nxt = 1'b0;
          state_nxt   = efla_pkg::ST_CHK;
        end
      end

      efla_pkg::ST_CHK: begin
        chk_sel_nxt = 1'b1;
        if (!chk_sel_r) begin
          len_ok_nxt = chk_ok;
        end else if (!len_ok_r || (!is_alloc && !chk_ok)) begin
          // The base only matters for a free.
          res_addr_nxt   = '0;
          res_status_nxt = efla_pkg::STAT_MISALIGN;
          state_nxt      = efla_pkg::ST_FIN;
        end else begin
          rd_idx_nxt = '0;
          pend_nxt   = 1'b0;
          state_nxt  = efla_pkg::ST_SCAN;
        end
      end

      efla_pkg::ST_SCAN: begin
        // Issue the next read while the previous entry is being compared.
        if (rd_idx_r < count_r) begin
          pend_nxt    = 1'b1;
          chk_idx_nxt = rd_idx_r[IW-1:0];
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end

        if (scan_hit) begin
          hit_idx_nxt  = chk_idx_r;
          hit_data_nxt = rd_data_r;
          hit_down_nxt = match_down;
          pend_nxt     = 1'b0;
          state_nxt    = efla_pkg::ST_WR;
        end else if (scan_done) begin
          res_addr_nxt = '0;
          state_nxt    = efla_pkg::ST_FIN;
          if (is_alloc) begin
            res_status_nxt = efla_pkg::STAT_NOFIT;
          end else if (count_r == MAX_CNT) begin
            res_status_nxt = efla_pkg::STAT_FULL;
          end else begin
            // Nothing adjoins the freed range: append it as a new extent.
            mem_we           = 1'b1;
            mem_waddr        = count_r[IW-1:0];
            mem_wdata.base   = base_r;
            mem_wdata.length = len_r;
            count_nxt        = count_r + 1'b1;
            free_nxt         = free_r + len_r;
            used_nxt         = used_r - len_r;
            res_status_nxt   = efla_pkg::STAT_OK;
          end
        end
      end

      efla_pkg::ST_WR: begin
        mem_we         = 1'b1;
        mem_waddr      = hit_idx_r;
        res_status_nxt = efla_pkg::STAT_OK;
        if (is_alloc) begin
          mem_wdata.base   = hit_data_r.base + len_r;
          mem_wdata.length = hit_data_r.length - len_r;
          res_addr_nxt     = hit_data_r.base;
          free_nxt         = free_r - len_r;
          used_nxt         = used_r + len_r;
        end else begin
          mem_wdata.base   = hit_down_r ? (hit_data_r.base - len_r) : hit_data_r.base;
          mem_wdata.length = hit_data_r.length + len_r;
          res_addr_nxt     = '0;
          free_nxt         = free_r + len_r;
          used_nxt         = used_r - len_r;
        end
        state_nxt = efla_pkg::ST_FIN;
      end

      efla_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          out_free_nxt   = free_r;
          out_used_nxt   = used_r;
          state_nxt      = efla_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = efla_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= efla_pkg::ST_IDLE;
      count_r     <= '0;
      free_r      <= '0;
      used_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      free_r      <= free_nxt;
      used_r      <= used_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    base_r       <= base_nxt;
    len_r        <= len_nxt;
    end_r        <= end_nxt;
    chk_sel_r    <= chk_sel_nxt;
    len_ok_r     <= len_ok_nxt;
    rd_idx_r     <= rd_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_data_r   <= hit_data_nxt;
    hit_down_r   <= hit_down_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_free_r   <= out_free_nxt;
    out_used_r   <= out_used_nxt;
  end

  // Extent table. A write never lands on an entry that the scan still has to compare, because
  // the write happens only after the scan has stopped issuing reads.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

`ifndef SYNTHESIS
  // The fill count never exceeds the table depth.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= MAX_CNT)
    else $error("extent count beyond table depth");

  // The fill count only ever grows by one, and only for a free.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + 1'b1) && $past(func_r == efla_pkg::FUNC_FREE))
    else $error("extent count changed unexpectedly");

  // A new result appears only when the sequencer hands one over.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r == efla_pkg::ST_FIN))
    else $error("result presented outside the hand-over state");

  // The table is written only on the write-back or when an append ends the scan.
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == efla_pkg::ST_WR) || (state_r == efla_pkg::ST_SCAN && scan_done))
    else $error("table written outside a write-back");
`endif

endmodule

### verif/efla_checker.sv
`timescale 1ns / 1ps
// Checker for the extent allocator: tracks the extent table, predicts each reply and compares.
module efla_checker
  import efla_pkg::*;
#(
  parameter int unsigned MAX_EXTENTS = MAX_EXTENTS_DEF,
  parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_total_ram,

  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_func,
  input  logic [31:0] in_base_addr,
  input  logic [31:0] in_length_bytes,

  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_alloc_addr,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_free_total,
  input  logic [31:0] out_used_total,

  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned words_checked,
  output int unsigned peak_fill,
  output logic [3:0]  status_seen
);

  typedef struct packed {
    logic [31:0] addr;
    status_t     status;
    logic [31:0] free_total;
    logic [31:0] used_total;
  } reply_t;

  // Shadow of the free-extent table and the running byte totals.
  logic [31:0] ext_base [MAX_EXTENTS];
  logic [31:0] ext_len  [MAX_EXTENTS];
  int unsigned fill;
  logic [31:0] free_bytes;
  logic [31:0] used_bytes;

  reply_t reply_q [$];

  // Applies one request to the shadow table and returns the reply it should produce.
  task automatic serve_request(input func_t op, input logic [31:0] base,
                               input logic [31:0] len, output reply_t r);
    logic [31:0] range_end;
    logic [31:0] ext_end;
    bit          done;
    done       = 1'b0;
    range_end  = base + len;
    r.addr     = '0;
    if (op == FUNC_ALLOC) begin
      if ((len % PAGE_BYTES) != 0) begin
        r.status = STAT_MISALIGN;
      end else begin
        r.status = STAT_NOFIT;
        for (int i = 0; i < fill; i++) begin
          if (!done && ext_len[i] >= len) begin
            r.addr      = ext_base[i];
            ext_base[i] = ext_base[i] + len;
            ext_len[i]  = ext_len[i] - len;
            free_bytes  = free_bytes - len;
            used_bytes  = used_bytes + len;
            r.status    = STAT_OK;
            done        = 1'b1;
          end
        end
      end
    end else begin
      if ((base % PAGE_BYTES) != 0 || (len % PAGE_BYTES) != 0) begin
        r.status = STAT_MISALIGN;
      end else begin
        r.status = STAT_OK;
        for (int i = 0; i < fill; i++) begin
          ext_end = ext_base[i] + ext_len[i];
          if (!done && ext_base[i] == range_end) begin
            ext_base[i] = ext_base[i] - len;
            ext_len[i]  = ext_len[i] + len;
            done        = 1'b1;
          end else if (!done && ext_end == base) begin
            ext_len[i]  = ext_len[i] + len;
            done        = 1'b1;
          end
        end
        if (!done && fill >= MAX_EXTENTS) begin
          r.status = STAT_FULL;
        end else if (!done) begin
          ext_base[fill] = base;
          ext_len[fill]  = len;
          fill++;
          done = 1'b1;
        end
        if (done) begin
          free_bytes = free_bytes + len;
          used_bytes = used_bytes - len;
        end
      end
    end
    r.free_total = free_bytes;
    r.used_total = used_bytes;
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t pred;
    if (!rst_n) begin
      fill          = 0;
      free_bytes    = '0;
      used_bytes    = '0;
      reply_q.delete();
      fail_count    = 0;
      pending       = 0;
      words_checked = 0;
      peak_fill     = 0;
      status_seen   = '0;
    end else begin
      // Replies are compared before new requests are predicted in the same cycle.
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: reply with nothing outstanding: addr %h status %0d free %h used %h",
                     $realtime, out_alloc_addr, out_status, out_free_total, out_used_total);
        end else begin
          want = reply_q.pop_front();
          words_checked++;
          status_seen[want.status] = 1'b1;
          if (out_alloc_addr !== want.addr || out_status !== want.status ||
              out_free_total !== want.free_total || out_used_total !== want.used_total) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: reply %0d differs: addr %h/%h status %0d/%0d free %h/%h used %h/%h",
                       $realtime, words_checked, want.addr, out_alloc_addr, want.status,
                       out_status, want.free_total, out_free_total, want.used_total,
                       out_used_total);
          end
        end
      end
      if (cfg_valid && cfg_ready)
        used_bytes = cfg_total_ram;
      if (in_valid && in_ready) begin
        serve_request(func_t'(in_func), in_base_addr, in_length_bytes, pred);
        reply_q.push_back(pred);
        if (fill > peak_fill)
          peak_fill = fill;
      end
      pending = reply_q.size();
    end
  end

endmodule

### verif/tb_extent_free_list_allocator.sv
`timescale 1ns / 1ps
// Testbench top for the extent allocator: clock, reset, request and reply traffic, verdict.
module tb_extent_free_list_allocator;
  import efla_pkg::*;

  localparam int unsigned PAGE        = PAGE_BYTES_DEF;
  localparam int unsigned WORDS_PHASE = 165;
  // A quiet spell this long means the block has stopped answering.
  localparam int unsigned QUIET_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_total_ram;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic [31:0] in_base_addr;
  logic [31:0] in_length_bytes;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_alloc_addr;
  logic [1:0]  out_status;
  logic [31:0] out_free_total;
  logic [31:0] out_used_total;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_checked;
  int unsigned peak_fill;
  logic [3:0]  status_seen;

  // Percentage of cycles in which the sender and the receiver hold back.
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned quiet_cycles;

  // Ends of the most recent free, so that later frees can land right next to it and
  // exercise merging in both directions.
  logic [31:0] last_base;
  logic [31:0] last_end;

  extent_free_list_allocator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_total_ram   (cfg_total_ram),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_base_addr    (in_base_addr),
    .in_length_bytes (in_length_bytes),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_alloc_addr  (out_alloc_addr),
    .out_status      (out_status),
    .out_free_total  (out_free_total),
    .out_used_total  (out_used_total)
  );

  efla_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_total_ram   (cfg_total_ram),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_base_addr    (in_base_addr),
    .in_length_bytes (in_length_bytes),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_alloc_addr  (out_alloc_addr),
    .out_status      (out_status),
    .out_free_total  (out_free_total),
    .out_used_total  (out_used_total),
    .fail_count      (fail_count),
    .pending         (pending),
    .words_checked   (words_checked),
    .peak_fill       (peak_fill),
    .status_seen     (status_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver decides afresh at every falling edge whether it will take a reply.
  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Watchdog: any accepted word on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("extent_free_list_allocator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request word, after a random number of idle cycles, and returns once it has
  // been accepted. Valid is left high so that a following word can follow without a gap.
  task automatic send_word(input func_t op, input logic [31:0] base, input logic [31:0] len);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_func         = op;
    in_base_addr    = base;
    in_length_bytes = len;
    do @(posedge clk); while (!in_ready);
  endtask

  // Withdraws the request channel and holds off until every predicted reply has come back.
  task automatic drain_replies();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Writes the total RAM size, which the block only takes while it is idle. A short pause
  // after the last reply lets the sequencer settle back into idle first.
  task automatic load_total_ram(input logic [31:0] value);
    drain_replies();
    repeat (10) @(negedge clk);
    cfg_valid     = 1'b1;
    cfg_total_ram = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One phase of random traffic. Most words are well-formed allocations and frees, many of
  // the frees placed right against the previous one so that extents merge; the rest are
  // scattered frees that fill the table, misaligned words and oversized requests.
  task automatic random_phase();
    int unsigned kind;
    logic [31:0] base;
    logic [31:0] len;
    for (int n = 0; n < WORDS_PHASE; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 32) begin
        send_word(FUNC_ALLOC, $urandom, PAGE * $urandom_range(0, 6));
      end else if (kind < 52) begin
        len = PAGE * $urandom_range(0, 4);
        base = $urandom_range(0, 1) ? last_end : last_base - len;
        last_base = base;
        last_end  = base + len;
        send_word(FUNC_FREE, base, len);
      end else if (kind < 66) begin
        len = PAGE * $urandom_range(0, 4);
        base = 32'h0010_0000 + PAGE * $urandom_range(0, 255);
        last_base = base;
        last_end  = base + len;
        send_word(FUNC_FREE, base, len);
      end else if (kind < 78) begin
        len = PAGE * $urandom_range(1, 16);
        base = $urandom & ~(PAGE - 1);
        last_base = base;
        last_end  = base + len;
        send_word(FUNC_FREE, base, len);
      end else if (kind < 90) begin
        send_word(func_t'($urandom_range(0, 1)), $urandom, $urandom);
      end else begin
        send_word(FUNC_ALLOC, $urandom, $urandom & ~(PAGE - 1));
      end
      // Now and then the sender stops altogether until the block has answered everything.
      if ($urandom_range(0, 39) == 0)
        drain_replies();
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_total_ram   = '0;
    in_valid        = 1'b0;
    in_func         = FUNC_ALLOC;
    in_base_addr    = '0;
    in_length_bytes = '0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 0;
    last_base       = 32'h0020_0000;
    last_end        = 32'h0020_0000;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: an empty table, misalignment of each field, merging in both directions,
    // a zero-length request, a request that cannot fit and ranges that wrap past the top.
    load_total_ram(32'h4000_0000);
    send_word(FUNC_ALLOC, '0, '0);
    send_word(FUNC_ALLOC, '0, 32'h0000_0001);
    send_word(FUNC_FREE, 32'h0000_1000, 32'h0000_1001);
    send_word(FUNC_FREE, 32'h0000_1001, 32'h0000_1000);
    send_word(FUNC_FREE, 32'h0001_0000, 32'h0000_4000);
    send_word(FUNC_FREE, 32'h0001_4000, 32'h0000_1000);
    send_word(FUNC_FREE, 32'h0000_F000, 32'h0000_1000);
    send_word(FUNC_ALLOC, 32'hFFFF_FFFF, '0);
    send_word(FUNC_ALLOC, '0, 32'h0000_2000);
    send_word(FUNC_ALLOC, '0, 32'h0010_0000);
    send_word(FUNC_FREE, 32'hFFFF_F000, 32'hFFFF_F000);
    send_word(FUNC_ALLOC, '0, 32'hFFFF_F000);
    send_word(FUNC_FREE, 32'hFFFF_F000, 32'h0000_1000);
    send_word(FUNC_FREE, '0, '0);
    send_word(FUNC_ALLOC, '0, 32'hFFFF_FFFF);
    send_word(FUNC_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(FUNC_FREE, 32'h8000_0000, 32'h7FFF_F000);
    send_word(FUNC_ALLOC, '0, 32'h7FFF_F000);

    // Three phases of random traffic, each with its own total RAM setting and idling pattern.
    load_total_ram(32'hFFFF_FFFF);
    tx_idle_pct = 38;
    rx_idle_pct = 79;
    random_phase();

    load_total_ram('0);
    tx_idle_pct = 79;
    rx_idle_pct = 38;
    random_phase();

    load_total_ram($urandom);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase();

    // Let the last replies come back, then keep watching for anything stray to appear.
    drain_replies();
    repeat (120) @(negedge clk);

    $display("Run covered %0d replies over four total RAM settings and three idling patterns.",
             words_checked);
    $display("Extent table filled to %0d entries; statuses returned (full..ok): %b.",
             peak_fill, status_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("extent_free_list_allocator: match");
    end else begin
      $display("extent_free_list_allocator: mismatch");
    end
    $finish;
  end

endmodule
